/* hw/rtl/sync_length_frame_receiver_core_macros.svh */
// Assertion macros for the sync/length frame receiver.
`ifndef SYNC_LENGTH_FRAME_RECEIVER_CORE_MACROS_SVH
`define SYNC_LENGTH_FRAME_RECEIVER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SLFR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slfr: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SLFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slfr: assertion failed");

`endif

/* hw/rtl/slfr_pkg.sv */
// Package with constants and types for the sync/length frame receiver.
`timescale 1ns / 1ps

package slfr_pkg;

   localparam int RX_BYTE_W      = 8;
   localparam int LEN_W          = 17;
   localparam int STATUS_W       = 2;
   localparam int STATION_ID_W   = 48;
   localparam int CSR_WDATA_W    = 48;
   localparam int CSR_INDEX_W    = 1;

   localparam int ID_BYTES_DEF   = 6;
   localparam int ID_BYTES_MAX   = 8;
   localparam int ID_IDX_W       = 3;
   localparam int ID_EXT_W       = 8 * ID_BYTES_MAX;

   localparam logic [RX_BYTE_W-1:0] SYNC_BYTE    = 8'hA5;
   localparam logic [RX_BYTE_W-1:0] END_FLAG     = 8'h40;
   localparam logic [LEN_W-1:0]     HEADER_BYTES = 17'd4;
   localparam logic [LEN_W-1:0]     MAX_FRAME_RST = 17'd256;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK          = 2'd0,
      STATUS_ID_MISMATCH = 2'd1,
      STATUS_BAD_END     = 2'd2,
      STATUS_TOO_SHORT   = 2'd3
   } frame_status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STATION_ID = 1'b0,
      CSR_MAX_FRAME  = 1'b1
   } csr_index_type;

endpackage

/* hw/rtl/sync_length_frame_receiver_core.sv */
// A frame's last byte passes the input register, then its result goes to the result register.
// Throughput: one byte per cycle unless stalled, with one pass of per-byte checks per byte.
// A stalled result holds the pipe only when the result register is full and stalled.
// Reset is synchronous, active high: hunt restarts, station ID 0, maximum frame size 256.
`timescale 1ns / 1ps
`include "sync_length_frame_receiver_core_macros.svh"

module sync_length_frame_receiver_core #(
   parameter int ID_BYTES = slfr_pkg::ID_BYTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [slfr_pkg::RX_BYTE_W-1:0]     req_rx_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [slfr_pkg::RX_BYTE_W-1:0]     rsp_cmd_type,
   output logic [slfr_pkg::LEN_W-1:0]         rsp_frame_len,
   output logic [slfr_pkg::STATUS_W-1:0]      rsp_frame_status,
   input  logic                               csr_write_en,
   input  logic [slfr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [slfr_pkg::CSR_WDATA_W-1:0]   csr_wdata
);

   import slfr_pkg::*;

   localparam logic [LEN_W-1:0] MIN_FRAME = LEN_W'(ID_BYTES + 6);
   localparam logic [LEN_W-1:0] ID_END    = LEN_W'(4 + ID_BYTES);
   localparam logic [ID_IDX_W-1:0] ID_LAST = ID_IDX_W'(ID_BYTES - 1);

   // configuration
   logic [STATION_ID_W-1:0] station_id_ff;
   logic [LEN_W-1:0]        max_frame_ff;

   // input stage
   logic                    s1_valid_ff, s1_valid_in;
   logic [RX_BYTE_W-1:0]    s1_byte_ff;
   logic                    s1_advance;
   logic                    req_accept;

   // frame state
   logic                    in_body_ff, in_body_in;
   logic [LEN_W-1:0]        byte_count_ff, byte_count_in;
   logic [LEN_W-1:0]        expected_len_ff, expected_len_in;
   logic [RX_BYTE_W-1:0]    length_high_ff, length_high_in;
   logic                    id_ok_ff, id_ok_in;
   logic [RX_BYTE_W-1:0]    captured_type_ff, captured_type_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RX_BYTE_W-1:0]    rsp_cmd_ff;
   logic [LEN_W-1:0]        rsp_len_ff;
   frame_status_type        rsp_status_ff;

   logic                    done;
   frame_status_type        status_calc;
   logic [LEN_W-1:0]        frame_len_calc;
   logic [LEN_W-1:0]        count_inc;
   logic [ID_EXT_W-1:0]     id_ext;
   logic [ID_IDX_W-1:0]     id_k;
   logic [ID_IDX_W-1:0]     id_sel;
   logic [RX_BYTE_W-1:0]    id_byte;

   assign s1_advance = !(rsp_valid_ff && rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_accept = req_valid && !req_stall;
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_advance);

   // station ID byte for the current frame position, first byte most significant
   assign id_ext  = {{(ID_EXT_W - STATION_ID_W){1'b0}}, station_id_ff};
   assign id_k    = byte_count_ff[ID_IDX_W-1:0] - HEADER_BYTES[ID_IDX_W-1:0];
   assign id_sel  = ID_LAST - id_k;
   assign id_byte = id_ext[{id_sel, 3'b000} +: RX_BYTE_W];

   assign frame_len_calc = {1'b0, length_high_ff, s1_byte_ff} + HEADER_BYTES;
   assign count_inc      = byte_count_ff + LEN_W'(1);

   always_comb begin
      in_body_in       = in_body_ff;
      byte_count_in    = byte_count_ff;
      expected_len_in  = expected_len_ff;
      length_high_in   = length_high_ff;
      id_ok_in         = id_ok_ff;
      captured_type_in = captured_type_ff;
      done             = 1'b0;
      if (s1_valid_ff && s1_advance) begin
         if (!in_body_ff) begin
            unique case (byte_count_ff)
               17'd0: begin
                  if (s1_byte_ff == SYNC_BYTE) begin
                     byte_count_in = 17'd1;
                  end
               end
               17'd1: begin
                  byte_count_in = (s1_byte_ff == SYNC_BYTE) ? 17'd2 : 17'd0;
               end
               17'd2: begin
                  length_high_in = s1_byte_ff;
                  byte_count_in  = 17'd3;
               end
               default: begin
                  expected_len_in = frame_len_calc;
                  if (frame_len_calc > max_frame_ff) begin
                     byte_count_in = '0;
                  end else begin
                     in_body_in       = 1'b1;
                     byte_count_in    = HEADER_BYTES;
                     id_ok_in         = 1'b1;
                     captured_type_in = '0;
                     done             = (frame_len_calc <= HEADER_BYTES);
                  end
               end
            endcase
         end else begin
            if (byte_count_ff < ID_END) begin
               if (s1_byte_ff != id_byte) begin
                  id_ok_in = 1'b0;
               end
            end else if (byte_count_ff == ID_END) begin
               captured_type_in = s1_byte_ff;
            end
            byte_count_in = count_inc;
            done          = (count_inc >= expected_len_ff);
         end
      end
      if (done) begin
         in_body_in    = 1'b0;
         byte_count_in = '0;
      end
   end

   always_comb begin
      priority if (expected_len_in < MIN_FRAME) begin
         status_calc = STATUS_TOO_SHORT;
      end else if (!id_ok_in) begin
         status_calc = STATUS_ID_MISMATCH;
      end else if (s1_byte_ff != END_FLAG) begin
         status_calc = STATUS_BAD_END;
      end else begin
         status_calc = STATUS_OK;
      end
   end

   assign rsp_valid_in = done || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         station_id_ff    <= '0;
         max_frame_ff     <= MAX_FRAME_RST;
         s1_valid_ff      <= 1'b0;
         in_body_ff       <= 1'b0;
         byte_count_ff    <= '0;
         expected_len_ff  <= '0;
         length_high_ff   <= '0;
         id_ok_ff         <= 1'b1;
         captured_type_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_STATION_ID: station_id_ff <= csr_wdata[STATION_ID_W-1:0];
               CSR_MAX_FRAME:  max_frame_ff  <= csr_wdata[LEN_W-1:0];
            endcase
         end
         s1_valid_ff      <= s1_valid_in;
         in_body_ff       <= in_body_in;
         byte_count_ff    <= byte_count_in;
         expected_len_ff  <= expected_len_in;
         length_high_ff   <= length_high_in;
         id_ok_ff         <= id_ok_in;
         captured_type_ff <= captured_type_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff <= req_rx_byte;
      end
      if (done) begin
         rsp_cmd_ff    <= (status_calc == STATUS_OK) ? captured_type_in : '0;
         rsp_len_ff    <= expected_len_in;
         rsp_status_ff <= status_calc;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cmd_type     = rsp_cmd_ff;
   assign rsp_frame_len    = rsp_len_ff;
   assign rsp_frame_status = rsp_status_ff;

   `SLFR_ASSERT_NOW(a_hunt_count, clock, reset, !in_body_ff, byte_count_ff <= 17'd3)
   `SLFR_ASSERT_NOW(a_body_count, clock, reset, in_body_ff,
      byte_count_ff < expected_len_ff)
   `SLFR_ASSERT_NOW(a_cmd_only_ok, clock, reset, rsp_valid_ff && rsp_cmd_ff != '0,
      rsp_status_ff == STATUS_OK)
   `SLFR_ASSERT_NOW(a_ok_len, clock, reset, rsp_valid_ff && rsp_status_ff == STATUS_OK,
      rsp_len_ff >= MIN_FRAME)
   `SLFR_ASSERT_NEXT(a_result_in_body, clock, reset,
      s1_valid_ff && s1_advance && in_body_ff && count_inc < expected_len_ff, in_body_ff)

endmodule
